// ----- design/qvr_pkg.sv -----
// shared widths, types and constants for the quaternion vector rotation pipeline
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

    localparam int QUAT_W   = 16;
    localparam int VEC_W    = 24;
    localparam int FRAC_W   = QUAT_W - 1;
    localparam int PROD_W   = 2 * QUAT_W;
    localparam int MAT_W    = PROD_W + 2;
    localparam int MAC_W    = MAT_W + VEC_W;
    localparam int ACC_W    = MAC_W + 2;
    localparam int SHIFT    = 2 * FRAC_W;
    localparam int RND_W    = ACC_W - SHIFT;
    localparam int DIM      = 3;
    localparam int MAT_N    = DIM * DIM;

    typedef logic signed [QUAT_W-1:0] quat_t;
    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [MAT_W-1:0]  mat_t;
    typedef logic signed [MAC_W-1:0]  mac_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [RND_W-1:0]  rnd_t;

    typedef vec_t vec3_t [DIM];
    typedef mat_t matrix_t [MAT_N];
    typedef mac_t mac9_t [MAT_N];
    typedef acc_t acc3_t [DIM];

    localparam vec_t VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
    localparam vec_t VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};
    localparam acc_t HALF    = acc_t'(1) <<< (SHIFT - 1);

endpackage

`default_nettype wire

// ----- design/qvr_matrix.sv -----
// quaternion pair products and rotation matrix, two register stages
`timescale 1ns / 1ps
`default_nettype none

module qvr_matrix
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             valid_in,
    output logic                  ready_in,
    input  wire qvr_pkg::quat_t   qw,
    input  wire qvr_pkg::quat_t   qi,
    input  wire qvr_pkg::quat_t   qj,
    input  wire qvr_pkg::quat_t   qk,
    input  wire qvr_pkg::vec3_t   vec_in,
    output logic                  valid_out,
    input  wire logic             ready_dn,
    output qvr_pkg::matrix_t      mat_out,
    output qvr_pkg::vec3_t        vec_out
);

    logic              va_reg;
    logic              vb_reg;
    logic              ready_b;
    qvr_pkg::prod_t    ww_reg, ii_reg, jj_reg, kk_reg, ij_reg;
    qvr_pkg::prod_t    ik_reg, jk_reg, wi_reg, wj_reg, wk_reg;
    qvr_pkg::vec3_t    vec_a_reg;
    qvr_pkg::vec3_t    vec_b_reg;
    qvr_pkg::matrix_t  mat_reg;
    qvr_pkg::matrix_t  mat_next;
    qvr_pkg::mat_t     eww, eii, ejj, ekk, eij, eik, ejk, ewi, ewj, ewk;

    assign ready_b  = !vb_reg || ready_dn;
    assign ready_in = !va_reg || ready_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (ready_in)
            begin
                va_reg <= valid_in;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    // products of quaternion part pairs
    always_ff @(posedge clk)
    begin
        if (ready_in && valid_in)
        begin
            ww_reg    <= qvr_pkg::prod_t'(qw) * qvr_pkg::prod_t'(qw);
            ii_reg    <= qvr_pkg::prod_t'(qi) * qvr_pkg::prod_t'(qi);
            jj_reg    <= qvr_pkg::prod_t'(qj) * qvr_pkg::prod_t'(qj);
            kk_reg    <= qvr_pkg::prod_t'(qk) * qvr_pkg::prod_t'(qk);
            ij_reg    <= qvr_pkg::prod_t'(qi) * qvr_pkg::prod_t'(qj);
            ik_reg    <= qvr_pkg::prod_t'(qi) * qvr_pkg::prod_t'(qk);
            jk_reg    <= qvr_pkg::prod_t'(qj) * qvr_pkg::prod_t'(qk);
            wi_reg    <= qvr_pkg::prod_t'(qw) * qvr_pkg::prod_t'(qi);
            wj_reg    <= qvr_pkg::prod_t'(qw) * qvr_pkg::prod_t'(qj);
            wk_reg    <= qvr_pkg::prod_t'(qw) * qvr_pkg::prod_t'(qk);
            vec_a_reg <= vec_in;
        end
    end

    always_comb
    begin
        eww = qvr_pkg::mat_t'(ww_reg);
        eii = qvr_pkg::mat_t'(ii_reg);
        ejj = qvr_pkg::mat_t'(jj_reg);
        ekk = qvr_pkg::mat_t'(kk_reg);
        eij = qvr_pkg::mat_t'(ij_reg);
        eik = qvr_pkg::mat_t'(ik_reg);
        ejk = qvr_pkg::mat_t'(jk_reg);
        ewi = qvr_pkg::mat_t'(wi_reg);
        ewj = qvr_pkg::mat_t'(wj_reg);
        ewk = qvr_pkg::mat_t'(wk_reg);
        mat_next[0] = eww + eii - ejj - ekk;
        mat_next[1] = (eij - ewk) <<< 1;
        mat_next[2] = (eik + ewj) <<< 1;
        mat_next[3] = (eij + ewk) <<< 1;
        mat_next[4] = eww - eii + ejj - ekk;
        mat_next[5] = (ejk - ewi) <<< 1;
        mat_next[6] = (eik - ewj) <<< 1;
        mat_next[7] = (ejk + ewi) <<< 1;
        mat_next[8] = eww - eii - ejj + ekk;
    end

    always_ff @(posedge clk)
    begin
        if (ready_b && va_reg)
        begin
            mat_reg   <= mat_next;
            vec_b_reg <= vec_a_reg;
        end
    end

    assign valid_out = vb_reg;
    assign mat_out   = mat_reg;
    assign vec_out   = vec_b_reg;

endmodule

`default_nettype wire

// ----- design/qvr_mac.sv -----
// matrix by vector products and row sums, two register stages
`timescale 1ns / 1ps
`default_nettype none

module qvr_mac
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid_in,
    output logic                   ready_in,
    input  wire qvr_pkg::matrix_t  mat_in,
    input  wire qvr_pkg::vec3_t    vec_in,
    output logic                   valid_out,
    input  wire logic              ready_dn,
    output qvr_pkg::acc3_t         acc_out
);

    logic            vc_reg;
    logic            vd_reg;
    logic            ready_d;
    qvr_pkg::mac9_t  mac_reg;
    qvr_pkg::acc3_t  acc_reg;

    assign ready_d  = !vd_reg || ready_dn;
    assign ready_in = !vc_reg || ready_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            if (ready_in)
            begin
                vc_reg <= valid_in;
            end
            if (ready_d)
            begin
                vd_reg <= vc_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_in && valid_in)
        begin
            for (int n = 0; n < qvr_pkg::MAT_N; n++)
            begin
                mac_reg[n] <= qvr_pkg::mac_t'(mat_in[n])
                            * qvr_pkg::mac_t'(vec_in[n % qvr_pkg::DIM]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_d && vc_reg)
        begin
            for (int r = 0; r < qvr_pkg::DIM; r++)
            begin
                acc_reg[r] <= qvr_pkg::acc_t'(mac_reg[r * qvr_pkg::DIM])
                            + qvr_pkg::acc_t'(mac_reg[r * qvr_pkg::DIM + 1])
                            + qvr_pkg::acc_t'(mac_reg[r * qvr_pkg::DIM + 2]);
            end
        end
    end

    assign valid_out = vd_reg;
    assign acc_out   = acc_reg;

endmodule

`default_nettype wire

// ----- design/qvr_round.sv -----
// round to nearest, saturate and hold the result for transfer
`timescale 1ns / 1ps
`default_nettype none

module qvr_round
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             valid_in,
    output logic                  ready_in,
    input  wire qvr_pkg::acc3_t   acc_in,
    output logic                  valid_out,
    input  wire logic             stall_dn,
    output qvr_pkg::vec3_t        rot_out,
    output logic                  sat_out
);

    logic            ve_reg;
    logic            sat_reg;
    logic            sat_next;
    qvr_pkg::vec3_t  rot_reg;
    qvr_pkg::vec3_t  rot_next;
    qvr_pkg::acc_t   sum;
    qvr_pkg::rnd_t   rnd;
    logic            ovf;

    assign ready_in = !ve_reg || !stall_dn;

    always_comb
    begin
        sat_next = 1'b0;
        sum      = '0;
        rnd      = '0;
        ovf      = 1'b0;
        for (int r = 0; r < qvr_pkg::DIM; r++)
        begin
            sum = acc_in[r] + qvr_pkg::HALF;
            rnd = sum[qvr_pkg::ACC_W-1:qvr_pkg::SHIFT];
            // upper bits beyond the output width must all match the sign
            ovf = !((&rnd[qvr_pkg::RND_W-1:qvr_pkg::VEC_W-1])
                    || !(|rnd[qvr_pkg::RND_W-1:qvr_pkg::VEC_W-1]));
            if (ovf)
            begin
                rot_next[r] = rnd[qvr_pkg::RND_W-1] ? qvr_pkg::VEC_MIN : qvr_pkg::VEC_MAX;
            end
            else
            begin
                rot_next[r] = rnd[qvr_pkg::VEC_W-1:0];
            end
            sat_next = sat_next | ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
        end
        else if (ready_in)
        begin
            ve_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_in && valid_in)
        begin
            rot_reg <= rot_next;
            sat_reg <= sat_next;
        end
    end

    assign valid_out = ve_reg;
    assign rot_out   = rot_reg;
    assign sat_out   = sat_reg;

endmodule

`default_nettype wire

// ----- design/quaternion_vector_rotation.sv -----
// top level of the quaternion vector rotation pipeline
//
//   channel   handshake                 payload
//   input     in_valid / in_stall       quat_w quat_i quat_j quat_k vec_x vec_y vec_z
//   output    out_valid / out_stall     rot_x rot_y rot_z saturated
//
// one transfer per cycle sustained while out_stall is low; five register stages from input to output
// stages in order: pair products, matrix, matrix-vector products, row sums, rounding
// reset clears only the stage valid bits; no clearing pass
// each stage holds while the stage after it is full and stalled, empty stages fill in
`timescale 1ns / 1ps
`default_nettype none

module quaternion_vector_rotation
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire qvr_pkg::quat_t  quat_w,
    input  wire qvr_pkg::quat_t  quat_i,
    input  wire qvr_pkg::quat_t  quat_j,
    input  wire qvr_pkg::quat_t  quat_k,
    input  wire qvr_pkg::vec_t   vec_x,
    input  wire qvr_pkg::vec_t   vec_y,
    input  wire qvr_pkg::vec_t   vec_z,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output qvr_pkg::vec_t        rot_x,
    output qvr_pkg::vec_t        rot_y,
    output qvr_pkg::vec_t        rot_z,
    output logic                 saturated
);

    logic              ready_mat;
    logic              valid_mat;
    logic              ready_mac;
    logic              valid_mac;
    logic              ready_rnd;
    qvr_pkg::vec3_t    vec_in;
    qvr_pkg::vec3_t    vec_mat;
    qvr_pkg::matrix_t  mat;
    qvr_pkg::acc3_t    acc;
    qvr_pkg::vec3_t    rot;

    assign vec_in[0] = vec_x;
    assign vec_in[1] = vec_y;
    assign vec_in[2] = vec_z;
    assign in_stall  = !ready_mat;

    qvr_matrix u_matrix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid),
        .ready_in  (ready_mat),
        .qw        (quat_w),
        .qi        (quat_i),
        .qj        (quat_j),
        .qk        (quat_k),
        .vec_in    (vec_in),
        .valid_out (valid_mat),
        .ready_dn  (ready_mac),
        .mat_out   (mat),
        .vec_out   (vec_mat)
    );

    qvr_mac u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid_mat),
        .ready_in  (ready_mac),
        .mat_in    (mat),
        .vec_in    (vec_mat),
        .valid_out (valid_mac),
        .ready_dn  (ready_rnd),
        .acc_out   (acc)
    );

    qvr_round u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid_mac),
        .ready_in  (ready_rnd),
        .acc_in    (acc),
        .valid_out (out_valid),
        .stall_dn  (out_stall),
        .rot_out   (rot),
        .sat_out   (saturated)
    );

    assign rot_x = rot[0];
    assign rot_y = rot[1];
    assign rot_z = rot[2];

endmodule

`default_nettype wire
